@@ rtl/task_dependency_scheduler_top_defines.svh @@
// Assertion macros for the task dependency scheduler.
// Used by the port checker; no other dependencies.
`ifndef TASK_DEPENDENCY_SCHEDULER_TOP_DEFINES_SVH
`define TASK_DEPENDENCY_SCHEDULER_TOP_DEFINES_SVH
`define TDS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TDS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    `TDS_ASSERT_IMPL(label, clk, rst_n, (cond) |=> (expr), msg)
`endif

@@ rtl/tds_pkg.sv @@
// Package for the task dependency scheduler: widths, op codes, command types.
// No dependencies.
package tds_pkg;
    localparam int MaxNodesDefault = 16;
    localparam int FieldLimit = 16;
    localparam int OpW = 3;
    localparam int IdW = 4;
    localparam int MaskW = 16;
    localparam int CountW = 5;

    typedef enum logic [2:0] {
        OP_DEFINE = 3'd0,
        OP_DONE   = 3'd1,
        OP_FAIL   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_ORDER  = 3'd4
    } op_t;

    typedef struct packed {
        logic apply_event;
        logic order_init;
        logic order_pop;
        logic scan_step;
        logic load_status;
        logic load_order;
        logic load_empty;
    } tds_cmd_t;

    typedef struct packed {
        logic queue_empty;
        logic scan_last;
        logic any_emitted;
    } tds_stat_t;
endpackage

@@ rtl/tds_stream_if.sv @@
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface tds_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tds_datapath.sv @@
// Datapath: node table, marks, order queue, Kahn scan and result register.
// Depends on tds_pkg.
module tds_datapath #(
    parameter int MAX_NODES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [tds_pkg::CountW-1:0] cfg_wdata,
    input  logic [tds_pkg::OpW-1:0]   op,
    input  logic [tds_pkg::IdW-1:0]   node_id,
    input  logic [tds_pkg::MaskW-1:0] dep_mask,
    input  tds_pkg::tds_cmd_t         cmd,
    output tds_pkg::tds_stat_t        stat,
    output logic [6:0]                res
);
    import tds_pkg::*;
    localparam int TabN = (MAX_NODES < FieldLimit) ? MAX_NODES : FieldLimit;
    localparam int QW = $clog2(TabN + 1);

    logic [MaskW-1:0] dep_reg [TabN];
    logic [MaskW-1:0] comp_reg, fail_reg, emit_reg, queued_reg;
    logic [CountW-1:0] count_reg;
    logic [IdW-1:0] queue_reg [TabN];
    logic [QW-1:0] head_reg, tail_reg;
    logic [IdW-1:0] cur_reg, scan_reg;
    logic [6:0] res_reg;
    logic any_reg;

    logic [CountW-1:0] n_use;
    logic [MaskW-1:0] live, done_m;
    logic all_done;
    logic [TabN-1:0] ready_v, root_v;
    logic st_valid;
    logic [IdW-1:0] st_node;
    logic [IdW-1:0] sel_id;
    logic scan_hit;
    logic [MaskW-1:0] emit_next;

    always_comb
    begin
        n_use = (count_reg > CountW'(TabN)) ? CountW'(TabN) : count_reg;
        live = MaskW'((17'd1 << n_use) - 17'd1);
        done_m = comp_reg & live;
        all_done = (done_m == live);
        st_valid = 1'b0;
        st_node = '0;
        for (int i = 0; i < TabN; i++)
        begin
            ready_v[i] = (CountW'(i) < n_use) && !comp_reg[i] && !fail_reg[i]
                && ((dep_reg[i] & ~done_m) == '0);
            root_v[i] = (CountW'(i) < n_use) && (dep_reg[i] == '0);
        end
        for (int i = TabN - 1; i >= 0; i--)
        begin
            if (ready_v[i])
            begin
                st_valid = 1'b1;
                st_node = IdW'(i);
            end
        end
        sel_id = scan_reg;
        emit_next = emit_reg;
        scan_hit = (CountW'(scan_reg) < n_use) && !queued_reg[sel_id]
            && dep_reg[sel_id][cur_reg] && ((dep_reg[sel_id] & ~emit_reg) == '0);
    end

    assign stat.queue_empty = (head_reg == tail_reg);
    assign stat.scan_last = (CountW'(scan_reg) + 1'b1 >= n_use);
    assign stat.any_emitted = any_reg;
    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TabN; i++) dep_reg[i] <= '0;
            comp_reg <= '0;
            fail_reg <= '0;
            emit_reg <= '0;
            queued_reg <= '0;
            count_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            cur_reg <= '0;
            scan_reg <= '0;
            any_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) count_reg <= cfg_wdata;
            if (cmd.apply_event)
            begin
                case (op)
                    OP_DEFINE:
                    begin
                        if (32'(node_id) < TabN)
                        begin
                            dep_reg[node_id[$clog2(TabN)-1:0]] <= dep_mask;
                            comp_reg[node_id] <= 1'b0;
                            fail_reg[node_id] <= 1'b0;
                        end
                    end
                    OP_DONE:
                    begin
                        if (CountW'(node_id) < n_use)
                        begin
                            comp_reg[node_id] <= 1'b1;
                            fail_reg[node_id] <= 1'b0;
                        end
                    end
                    OP_FAIL:
                    begin
                        if (CountW'(node_id) < n_use) fail_reg[node_id] <= 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        comp_reg <= '0;
                        fail_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.order_init)
            begin
                logic [QW-1:0] t;
                t = '0;
                emit_reg <= '0;
                any_reg <= 1'b0;
                queued_reg <= MaskW'(root_v);
                for (int i = 0; i < TabN; i++)
                begin
                    if (root_v[i])
                    begin
                        queue_reg[t[$clog2(TabN)-1:0]] <= IdW'(i);
                        t = t + 1'b1;
                    end
                end
                head_reg <= '0;
                tail_reg <= t;
            end
            if (cmd.order_pop)
            begin
                cur_reg <= queue_reg[head_reg[$clog2(TabN)-1:0]];
                emit_reg <= emit_next
                    | (MaskW'(1) << queue_reg[head_reg[$clog2(TabN)-1:0]]);
                head_reg <= head_reg + 1'b1;
                scan_reg <= '0;
                any_reg <= 1'b1;
            end
            if (cmd.scan_step)
            begin
                if (scan_hit && 32'(tail_reg) < TabN)
                begin
                    queue_reg[tail_reg[$clog2(TabN)-1:0]] <= scan_reg;
                    tail_reg <= tail_reg + 1'b1;
                    queued_reg[sel_id] <= 1'b1;
                end
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_status)
            res_reg <= {st_valid, st_valid ? st_node : IdW'(0), all_done, 1'b1};
        else if (cmd.load_order)
            res_reg <= {1'b1, cur_reg, all_done, stat.queue_empty};
        else if (cmd.load_empty)
            res_reg <= {1'b0, IdW'(0), all_done, 1'b1};
    end
endmodule

@@ rtl/tds_ctrl.sv @@
// Controller FSM: sequences events, the Kahn scan and result handoff.
// Depends on tds_pkg.
module tds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [tds_pkg::OpW-1:0] op,
    output logic               out_valid,
    input  logic               out_ready,
    input  tds_pkg::tds_stat_t stat,
    output tds_pkg::tds_cmd_t  cmd
);
    import tds_pkg::*;
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_STAT  = 6'b000010,
        S_POP   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_OUT   = 6'b010000,
        S_ORDER = 6'b100000
    } state_t;
    state_t state_reg, state_next;
    logic ov_reg, ov_next;

    assign out_valid = ov_reg;
    assign in_ready = (state_reg == S_IDLE) && (!ov_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (op == OP_ORDER)
                    begin
                        cmd.order_init = 1'b1;
                        state_next = S_ORDER;
                    end
                    else
                    begin
                        cmd.apply_event = 1'b1;
                        state_next = S_STAT;
                    end
                end
            end
            S_STAT:
            begin
                cmd.load_status = 1'b1;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            S_ORDER:
            begin
                if (stat.queue_empty)
                begin
                    if (!stat.any_emitted)
                    begin
                        if (!ov_reg || out_ready)
                        begin
                            cmd.load_empty = 1'b1;
                            ov_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else state_next = S_IDLE;
                end
                else state_next = S_POP;
            end
            S_POP:
            begin
                cmd.order_pop = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.load_order = 1'b1;
                    state_next = S_ORDER;
                    ov_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule

@@ rtl/tds_result.sv @@
// Order result staging: captures emitted node for the output register.
// Depends on tds_pkg.
module tds_result (
    input  logic       clk,
    input  logic       cap,
    input  logic       sel_order,
    input  logic [6:0] status_res,
    input  logic [4:0] node_in,
    input  logic       done_in,
    output logic [6:0] res
);
    import tds_pkg::*;
    logic [6:0] ord_reg;
    always_ff @(posedge clk)
    begin
        if (cap) ord_reg <= {1'b1, node_in[3:0], done_in, node_in[4]};
    end
    assign res = sel_order ? ord_reg : status_res;
endmodule

@@ rtl/task_dependency_scheduler_top.sv @@
// Task dependency scheduler (index-based Kahn topological sort), top level.
// Channels: in_ch carries op, node_id, dep_mask; out_ch carries
// node_valid, node_out, all_done, last. Config: cfg_we/cfg_wdata = node_count.
// A define/completed/failed/clear/query item gives one result, loaded into the
// output register in the cycle after acceptance. An order item runs Kahn's
// algorithm: roots are queued together on acceptance, then each emitted node
// goes through a queue check, a pop, a scan of the N nodes in use looking for
// newly ready dependents, and a result load.
// One item is in work at a time; ready is low until its last result has
// entered the output register. The output register holds a result until
// out_ch.ready; a stalled receiver stalls the order walk.
// Reset clears the node table, all marks and node_count; the order queue
// is written before it is read and has no reset.
module task_dependency_scheduler_top #(
    parameter int MAX_NODES = tds_pkg::MaxNodesDefault
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [tds_pkg::CountW-1:0] cfg_wdata,
    tds_stream_if.sink                 in_ch,
    tds_stream_if.source               out_ch
);
    import tds_pkg::*;
    tds_cmd_t cmd;
    tds_stat_t stat;
    logic [6:0] dres, ores;

    tds_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .op(in_ch.data[OpW+IdW+MaskW-1 -: OpW]),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    tds_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .op(in_ch.data[OpW+IdW+MaskW-1 -: OpW]),
        .node_id(in_ch.data[IdW+MaskW-1 -: IdW]),
        .dep_mask(in_ch.data[MaskW-1:0]),
        .cmd(cmd), .stat(stat), .res(dres)
    );

    tds_result u_res (
        .clk(clk), .cap(cmd.order_pop), .sel_order(1'b0),
        .status_res(dres), .node_in(5'(dres[5:2])), .done_in(dres[1]), .res(ores)
    );

    assign out_ch.data = ores;
endmodule

@@ rtl/tds_checker.sv @@
// Port checker for the scheduler top level, bound to it.
// Depends on task_dependency_scheduler_top_defines.svh.
`include "task_dependency_scheduler_top_defines.svh"
module tds_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] out_data
);
    `TDS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
    `TDS_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "accepted while busy")
    `TDS_ASSERT_IMPL(a_zero, clk, rst_n, out_valid && !out_data[6] |-> out_data[5:2] == 4'd0 && out_data[0], "invalid result not clean")
endmodule

bind task_dependency_scheduler_top tds_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
